@@ hdl/tlptw_pkg.sv @@
// Package for the two-level page table walker.
// Holds beat types, result codes, walk phases, register indexes and entry bit masks.
// Used by every module in this folder.
package tlptw_pkg;

    localparam int RES_MAX   = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [31:0] PRESENT_BIT  = 32'h0000_0001;
    localparam logic [31:0] ACCESSED_BIT = 32'h0000_0020;
    localparam logic [31:0] DIRTY_BIT    = 32'h0000_0040;
    localparam logic [31:0] FRAME_MASK   = 32'hFFFF_F000;
    localparam logic [31:0] OFFSET_MASK  = 32'h0000_0FFF;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGING_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_BASE      = 1'b1;

    typedef enum logic {
        ACT_REQUEST = 1'b0,
        ACT_DATA    = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_FAULT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DIR   = 2'd1,
        PH_TABLE = 2'd2
    } t_phase;

    typedef struct packed {
        logic        action;
        logic [31:0] vaddr;
        logic        is_read;
        logic [31:0] read_data;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] mem_addr;
        logic [31:0] write_data;
        logic [31:0] phys_addr;
        logic        fault_level;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]              count;
        t_out_item [RES_MAX-1:0] items;
    } t_walk_res;

    typedef struct packed {
        logic        paging_enable;
        logic [31:0] dir_base;
    } t_cfg;

    function automatic t_out_item mk_res(t_kind kind, logic [31:0] mem_addr,
                                         logic [31:0] write_data, logic [31:0] phys_addr,
                                         logic fault_level, logic last);
        t_out_item r;
        r.kind        = kind;
        r.mem_addr    = mem_addr;
        r.write_data  = write_data;
        r.phys_addr   = phys_addr;
        r.fault_level = fault_level;
        r.last        = last;
        return r;
    endfunction

endpackage

@@ hdl/two_level_page_table_walker_top.sv @@
// Top level of the two-level page table walker.
// Holds the input register and configuration registers; uses tlptw_walk, tlptw_outq, tlptw_pkg.
//
// channel | direction | handshake               | beat
// in      | input     | i_in_valid / o_in_stall  | t_in_item
// out     | output    | o_out_valid / i_out_stall | t_out_item
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A beat waits in the input register, then its results load the result buffer; the
// buffer drains one result per cycle unless the output stalls. An item yields one result
// for a request, a fault or a directory hit, none for ignored data, and three for a walk.
// Reset clears walk state, configuration and buffer counts; cfg is always ready.
// Output stall holds the buffer; the input register waits until the buffer is empty
// or holds one result that leaves in the same cycle.
module two_level_page_table_walker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tlptw_pkg::t_in_item                 i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tlptw_pkg::t_out_item                o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tlptw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);
    import tlptw_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    t_cfg      r_cfg;
    t_walk_res res;
    logic      can_load;
    logic      advance;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && can_load;
    assign o_in_stall  = r_in_valid && !can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PAGING_ENABLE: r_cfg.paging_enable <= i_cfg_data[0];
                CFG_DIR_BASE:      r_cfg.dir_base      <= i_cfg_data;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    tlptw_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_item  (r_in_item),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    tlptw_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_res      (res),
        .i_stall    (i_out_stall),
        .o_valid    (o_out_valid),
        .o_item     (o_out_item),
        .o_can_load (can_load)
    );

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.last |=> o_out_valid)
        else $error("result burst broken before its last beat");

    a_fault_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind == KIND_FAULT) |-> o_out_item.last)
        else $error("fault result not marked last");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while results are stalled and register full");

    a_held_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_item))
        else $error("stalled input register changed");

endmodule

@@ hdl/tlptw_walk.sv @@
// Walk step logic and walk state registers for the page table walker.
// Turns one registered beat into up to three results. Depends on tlptw_pkg.
module tlptw_walk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  tlptw_pkg::t_in_item i_item,
    input  tlptw_pkg::t_cfg     i_cfg,
    output tlptw_pkg::t_walk_res o_res
);
    import tlptw_pkg::*;

    t_phase      r_phase,    n_phase;
    logic [31:0] r_vaddr,    n_vaddr;
    logic        r_is_read,  n_is_read;
    logic [31:0] r_dir,      n_dir;
    logic [31:0] r_dir_addr, n_dir_addr;

    logic [31:0] tbl_addr_new;
    logic [31:0] tbl_addr_held;
    logic [31:0] phys;
    logic [31:0] pde;
    logic [31:0] pte;
    logic [31:0] upd_bits;

    always_comb begin
        n_phase    = r_phase;
        n_vaddr    = r_vaddr;
        n_is_read  = r_is_read;
        n_dir      = r_dir;
        n_dir_addr = r_dir_addr;
        o_res      = '0;

        tbl_addr_new  = (i_item.read_data & FRAME_MASK)
                      + {20'b0, r_vaddr[21:12], 2'b00};
        tbl_addr_held = (r_dir & FRAME_MASK) + {20'b0, r_vaddr[21:12], 2'b00};
        phys          = (i_item.read_data & FRAME_MASK) + (r_vaddr & OFFSET_MASK);
        upd_bits      = r_is_read ? ACCESSED_BIT : (ACCESSED_BIT | DIRTY_BIT);
        pde           = r_dir | upd_bits;
        pte           = i_item.read_data | upd_bits;

        if (i_item.action == ACT_REQUEST) begin
            o_res.count = 2'd1;
            if (!i_cfg.paging_enable) begin
                n_phase        = PH_IDLE;
                o_res.items[0] = mk_res(KIND_DONE, '0, '0, i_item.vaddr, 1'b0, 1'b1);
            end else begin
                n_vaddr        = i_item.vaddr;
                n_is_read      = i_item.is_read;
                n_dir_addr     = i_cfg.dir_base + {20'b0, i_item.vaddr[31:22], 2'b00};
                n_phase        = PH_DIR;
                o_res.items[0] = mk_res(KIND_READ, n_dir_addr, '0, '0, 1'b0, 1'b1);
            end
        end else begin
            case (r_phase)
                PH_DIR: begin
                    o_res.count = 2'd1;
                    if ((i_item.read_data & PRESENT_BIT) == '0) begin
                        n_phase        = PH_IDLE;
                        o_res.items[0] = mk_res(KIND_FAULT, '0, '0, '0, 1'b0, 1'b1);
                    end else begin
                        n_dir          = i_item.read_data;
                        n_phase        = PH_TABLE;
                        o_res.items[0] = mk_res(KIND_READ, tbl_addr_new, '0, '0,
                                                1'b0, 1'b1);
                    end
                end
                PH_TABLE: begin
                    n_phase = PH_IDLE;
                    if ((i_item.read_data & PRESENT_BIT) == '0) begin
                        o_res.count    = 2'd1;
                        o_res.items[0] = mk_res(KIND_FAULT, '0, '0, '0, 1'b1, 1'b1);
                    end else begin
                        o_res.count    = 2'd3;
                        o_res.items[0] = mk_res(KIND_WRITE, r_dir_addr, pde, '0,
                                                1'b0, 1'b0);
                        o_res.items[1] = mk_res(KIND_WRITE, tbl_addr_held, pte, '0,
                                                1'b0, 1'b0);
                        o_res.items[2] = mk_res(KIND_DONE, '0, '0, phys, 1'b0, 1'b1);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_vaddr    <= '0;
            r_is_read  <= 1'b0;
            r_dir      <= '0;
            r_dir_addr <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_vaddr    <= n_vaddr;
            r_is_read  <= n_is_read;
            r_dir      <= n_dir;
            r_dir_addr <= n_dir_addr;
        end
    end

endmodule

@@ hdl/tlptw_outq.sv @@
// Result buffer for the page table walker.
// Loads up to three results at once and drains one beat per cycle while not stalled. Depends on tlptw_pkg.
module tlptw_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  tlptw_pkg::t_walk_res i_res,
    input  logic                 i_stall,
    output logic                 o_valid,
    output tlptw_pkg::t_out_item o_item,
    output logic                 o_can_load
);
    import tlptw_pkg::*;

    t_out_item  r_slot [RES_MAX];
    logic [1:0] r_cnt;
    logic       drain;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_slot[0];
    assign drain      = o_valid && !i_stall;
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_res.count;
        end else if (drain) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < RES_MAX; k++) begin
                r_slot[k] <= i_res.items[k];
            end
        end else if (drain) begin
            for (int k = 0; k < RES_MAX - 1; k++) begin
                r_slot[k] <= r_slot[k+1];
            end
        end
    end

endmodule

@@ tb/tlptw_walk_checker.sv @@
// Checker for the two-level page table walker: watches the in, out and cfg channels.
// Predicts every result beat from accepted input beats and compares them field by field.
// Depends on tlptw_pkg for beat types, result kinds, walk phases and entry masks.
module tlptw_walk_checker
    import tlptw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_item,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output int                   o_pending,
    output int                   o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    t_out_item   walk_results_q[$];
    t_cfg        cfg_shadow;
    t_phase      phase;
    logic [31:0] held_va;
    logic        held_rd;
    logic [31:0] held_pde;
    logic [31:0] held_pde_addr;
    int          err_cnt = 0;

    function automatic t_out_item beat_of(t_kind kind, logic [31:0] mem_addr,
                                          logic [31:0] write_data, logic [31:0] phys_addr,
                                          logic fault_level, logic last);
        t_out_item r;
        r.kind        = kind;
        r.mem_addr    = mem_addr;
        r.write_data  = write_data;
        r.phys_addr   = phys_addr;
        r.fault_level = fault_level;
        r.last        = last;
        return r;
    endfunction

    task automatic predict_walk(input t_in_item it);
        logic [31:0] pte_addr;
        logic [31:0] pde_new;
        logic [31:0] pte_new;
        if (it.action == ACT_REQUEST) begin
            if (!cfg_shadow.paging_enable) begin
                phase = PH_IDLE;
                walk_results_q.push_back(beat_of(KIND_DONE, '0, '0, it.vaddr, 1'b0, 1'b1));
            end else begin
                held_va       = it.vaddr;
                held_rd       = it.is_read;
                held_pde_addr = cfg_shadow.dir_base + {20'b0, it.vaddr[31:22], 2'b00};
                phase         = PH_DIR;
                walk_results_q.push_back(beat_of(KIND_READ, held_pde_addr, '0, '0, 1'b0, 1'b1));
            end
        end else begin
            case (phase)
                PH_DIR: begin
                    if ((it.read_data & PRESENT_BIT) == '0) begin
                        phase = PH_IDLE;
                        walk_results_q.push_back(beat_of(KIND_FAULT, '0, '0, '0, 1'b0, 1'b1));
                    end else begin
                        held_pde = it.read_data;
                        pte_addr = (it.read_data & FRAME_MASK) + {20'b0, held_va[21:12], 2'b00};
                        phase    = PH_TABLE;
                        walk_results_q.push_back(beat_of(KIND_READ, pte_addr, '0, '0, 1'b0, 1'b1));
                    end
                end
                PH_TABLE: begin
                    phase = PH_IDLE;
                    if ((it.read_data & PRESENT_BIT) == '0) begin
                        walk_results_q.push_back(beat_of(KIND_FAULT, '0, '0, '0, 1'b1, 1'b1));
                    end else begin
                        pte_addr = (held_pde & FRAME_MASK) + {20'b0, held_va[21:12], 2'b00};
                        pde_new  = held_pde | ACCESSED_BIT;
                        pte_new  = it.read_data | ACCESSED_BIT;
                        if (!held_rd) begin
                            pde_new = pde_new | DIRTY_BIT;
                            pte_new = pte_new | DIRTY_BIT;
                        end
                        walk_results_q.push_back(beat_of(KIND_WRITE, held_pde_addr, pde_new,
                                                         '0, 1'b0, 1'b0));
                        walk_results_q.push_back(beat_of(KIND_WRITE, pte_addr, pte_new,
                                                         '0, 1'b0, 1'b0));
                        walk_results_q.push_back(beat_of(KIND_DONE, '0, '0,
                                                         (it.read_data & FRAME_MASK) +
                                                         (held_va & OFFSET_MASK),
                                                         1'b0, 1'b1));
                    end
                end
                default: begin
                    phase = PH_IDLE;
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    task automatic compare_beat(input t_out_item got);
        t_out_item want;
        if (walk_results_q.size() == 0) begin
            $display("%0t ns: unexpected result beat: expected none, actual %h", $time, got);
            err_cnt++;
        end else begin
            want = walk_results_q.pop_front();
            check_field("kind",        32'(want.kind),        32'(got.kind));
            check_field("mem_addr",    want.mem_addr,         got.mem_addr);
            check_field("write_data",  want.write_data,       got.write_data);
            check_field("phys_addr",   want.phys_addr,        got.phys_addr);
            check_field("fault_level", 32'(want.fault_level), 32'(got.fault_level));
            check_field("last",        32'(want.last),        32'(got.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_shadow    = '0;
            phase         = PH_IDLE;
            held_va       = '0;
            held_rd       = 1'b0;
            held_pde      = '0;
            held_pde_addr = '0;
            walk_results_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                compare_beat(i_out_item);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_PAGING_ENABLE) begin
                    cfg_shadow.paging_enable = i_cfg_data[0];
                end else begin
                    cfg_shadow.dir_base = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_walk(i_in_item);
            end
        end
        o_pending <= walk_results_q.size();
        o_errors  <= err_cnt;
    end

endmodule

@@ tb/tb.sv @@
// Testbench top for the two-level page table walker: clock, reset, stimulus and verdict.
// Drives directed and random walks under several register settings with random idling.
// Depends on tlptw_pkg, two_level_page_table_walker_top and tlptw_walk_checker.
module tb;
    import tlptw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT     = 400000;
    localparam int IDLE_TAIL = 8;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_stall;
    t_out_item            out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    int                   pending;
    int                   errors;
    bit                   calm = 1'b0;
    int                   cycles = 0;

    always #5 clk = ~clk;

    two_level_page_table_walker_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tlptw_walk_checker u_walk_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] entry_word(input bit present);
        logic [31:0] w;
        w    = $urandom;
        w[0] = present;
        return w;
    endfunction

    task automatic drive_in(input t_in_item it);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_req(input logic [31:0] va, input logic rd);
        t_in_item it;
        it.action    = ACT_REQUEST;
        it.vaddr     = va;
        it.is_read   = rd;
        it.read_data = $urandom;
        drive_in(it);
    endtask

    task automatic send_data(input logic [31:0] d);
        t_in_item it;
        it.action    = ACT_DATA;
        it.vaddr     = $urandom;
        it.is_read   = 1'($urandom);
        it.read_data = d;
        drive_in(it);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic set_cfg(input logic pe, input logic [31:0] base);
        logic [31:0] pe_word;
        wait_idle();
        pe_word    = $urandom;
        pe_word[0] = pe;
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PAGING_ENABLE;
        cfg_data  <= pe_word;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_DIR_BASE;
        cfg_data  <= base;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input bit paging_on);
        int          sent;
        int          pick;
        logic [31:0] pde;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (!paging_on) begin
                if (pick < 85) begin
                    send_req($urandom, 1'($urandom));
                    sent++;
                end else begin
                    send_data($urandom);
                end
            end else if (pick < 70) begin
                send_req($urandom, 1'($urandom));
                pde = entry_word($urandom_range(0, 9) != 0);
                send_data(pde);
                sent += 2;
                if (pde[0]) begin
                    send_data(entry_word($urandom_range(0, 9) != 0));
                    sent++;
                end
            end else if (pick < 80) begin
                send_req($urandom, 1'($urandom));
                sent++;
                if ($urandom_range(0, 1)) begin
                    send_data(entry_word(1'b1));
                    sent++;
                end
            end else if (pick < 90) begin
                send_data($urandom);
            end else begin
                send_req($urandom, 1'($urandom));
                send_req($urandom, 1'($urandom));
                sent += 2;
            end
        end
    endtask

    initial begin
        out_stall <= 1'b0;
        forever begin
            int run;
            int len;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            len = calm ? 0 : pick_gap();
            if (len > 0) begin
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("two_level_page_table_walker_top regression: fail");
        $finish;
    end

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_PAGING_ENABLE;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // data with no walk in progress, then pass-through with paging off
        send_data(32'hFFFF_FFFF);
        send_req(32'h0000_0000, 1'b1);
        send_req(32'hFFFF_FFFF, 1'b0);

        set_cfg(1'b1, 32'h0000_0000);
        send_req(32'hFFFF_FFFF, 1'b0);
        send_data(32'hFFFF_FFFF);
        send_data(32'hFFFF_FFFF);
        send_req(32'h0000_0000, 1'b1);
        send_data(32'h0000_0001);
        send_data(32'h0000_0001);
        // absent directory entry, then absent table entry
        send_req(32'h8040_1ABC, 1'b1);
        send_data(32'hFFFF_FFFE);
        send_req(32'h1234_5678, 1'b0);
        send_data(32'h0000_3001);
        send_data(32'h0000_0000);
        // abandon a walk waiting on each level
        send_req(32'h0040_0000, 1'b1);
        send_req(32'h0FF0_0FFF, 1'b0);
        send_data(32'h0001_2001);
        send_req(32'hFFC0_0000, 1'b1);
        send_data(32'h7FFF_F001);
        send_data(32'h8000_0001);
        send_data(32'h0000_0001);

        // address sums that wrap
        set_cfg(1'b1, 32'hFFFF_FFFF);
        send_req(32'hFFFF_FFFF, 1'b1);
        send_data(32'hFFFF_F001);
        send_data(32'hFFFF_F001);

        set_cfg(1'b0, $urandom);
        run_phase(64, 1'b0);
        set_cfg(1'b1, 32'h0000_0000);
        run_phase(64, 1'b1);
        calm = 1'b1;
        set_cfg(1'b1, 32'hFFFF_FFFF);
        run_phase(64, 1'b1);
        calm = 1'b0;
        set_cfg(1'b1, $urandom);
        run_phase(64, 1'b1);
        set_cfg(1'b1, $urandom & FRAME_MASK);
        run_phase(64, 1'b1);

        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("two_level_page_table_walker_top regression: pass");
        end else begin
            $display("two_level_page_table_walker_top regression: fail");
        end
        $finish;
    end

endmodule

@@ two_level_page_table_walker_top.f @@
hdl/tlptw_pkg.sv
hdl/tlptw_walk.sv
hdl/tlptw_outq.sv
hdl/two_level_page_table_walker_top.sv
tb/tlptw_walk_checker.sv
tb/tb.sv
